@@ rtl/sawarq_pkg.sv @@
package sawarq_pkg;

	// Default length width of a transfer
	localparam int LENGTH_BITS_DEF = 32;

	// Fixed field widths
	localparam int FILE_LEN_W = 32;
	localparam int PAYLOAD_W  = 8;
	localparam int TIMEOUT_W  = 16;
	localparam int CFG_DATA_W = 16;
	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = 80;

	// Configuration register indexes
	localparam logic CFG_PAYLOAD = 1'b0;
	localparam logic CFG_TIMEOUT = 1'b1;

	localparam logic [PAYLOAD_W-1:0] PAYLOAD_RST = 8'd232;
	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 16'd60;

	// Input item kinds
	localparam logic [1:0] KIND_START = 2'd0;
	localparam logic [1:0] KIND_TICK  = 2'd1;
	localparam logic [1:0] KIND_FRAME = 2'd2;

	// Received frame types
	localparam logic [1:0] RX_ACK = 2'd0;

	// Result actions
	localparam logic [1:0] ACT_DATA = 2'd0;
	localparam logic [1:0] ACT_FIN  = 2'd1;
	localparam logic [1:0] ACT_DONE = 2'd2;

	// Protocol phases
	localparam logic [2:0] PH_IDLE   = 3'd0;
	localparam logic [2:0] PH_DATA   = 3'd1;
	localparam logic [2:0] PH_FIN    = 3'd2;
	localparam logic [2:0] PH_LINGER = 3'd3;
	localparam logic [2:0] PH_DONE   = 3'd4;

	typedef struct packed {
		logic capture;
		logic div_start;
		logic div_step;
		logic commit;
	} ctl_cmd_t;

	typedef struct packed {
		logic need_div;
		logic div_last;
		logic has_result;
		logic out_free;
	} ctl_sts_t;

endpackage

@@ rtl/sawarq_ctrl.sv @@
module sawarq_ctrl
	import sawarq_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	output logic     s_tready,
	input  ctl_sts_t sts,
	output ctl_cmd_t cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EVAL = 2'd1;
	localparam logic [1:0] S_DIV  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign s_tready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.capture = 1'b1;
					state_d = S_EVAL;
				end
			end
			S_EVAL: begin
				if (sts.need_div) begin
					cmd.div_start = 1'b1;
					state_d = S_DIV;
				end else if (!sts.has_result || sts.out_free) begin
					// hold here while a result cannot yet be loaded
					cmd.commit = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = S_EVAL;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ rtl/sawarq_dpath.sv @@
module sawarq_dpath
	import sawarq_pkg::*;
#(
	parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ctl_cmd_t              cmd,
	output ctl_sts_t              sts,
	input  logic [1:0]            in_kind,
	input  logic [FILE_LEN_W-1:0] in_file_length,
	input  logic [1:0]            in_rx_type,
	input  logic                  in_rx_seq,
	input  logic                  cfg_we,
	input  logic                  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  out_ready,
	output logic                  out_valid,
	output logic [1:0]            out_action,
	output logic                  out_seq_bit,
	output logic [FILE_LEN_W-1:0] out_chunks_left,
	output logic [PAYLOAD_W-1:0]  out_frame_length,
	output logic [FILE_LEN_W-1:0] out_byte_offset,
	output logic                  out_is_retransmit
);

	// lengths and offsets never need more than the 32-bit fields
	localparam int LW = (LENGTH_BITS < FILE_LEN_W) ? LENGTH_BITS : FILE_LEN_W;
	localparam int CW = $clog2(LW);

	// configuration
	logic [PAYLOAD_W-1:0] payload_q;
	logic [TIMEOUT_W-1:0] timeout_q;

	// protocol state
	logic [2:0]           phase_q;
	logic                 seq_q;
	logic [LW-1:0]        chunks_q;
	logic [PAYLOAD_W-1:0] last_q;
	logic [LW-1:0]        offset_q;
	logic [TIMEOUT_W-1:0] timer_q;

	// captured item
	logic [1:0]    kind_q;
	logic [LW-1:0] len_q;
	logic [1:0]    rxt_q;
	logic          rxs_q;

	// divider
	logic [LW-1:0]        quo_q;
	logic [PAYLOAD_W-1:0] rem_q;
	logic [CW-1:0]        cnt_q;
	logic                 div_done_q;

	logic [PAYLOAD_W-1:0] pay;
	logic [TIMEOUT_W-1:0] limit;
	logic [PAYLOAD_W:0]   trial;
	logic [PAYLOAD_W:0]   trial_sub;
	logic                 trial_ge;

	// next state and result
	logic [2:0]           n_phase;
	logic                 n_seq;
	logic [LW-1:0]        n_chunks;
	logic [PAYLOAD_W-1:0] n_last;
	logic [LW-1:0]        n_offset;
	logic [TIMEOUT_W-1:0] n_timer;
	logic [TIMEOUT_W-1:0] timer_inc;
	logic                 expired;
	logic                 e_data;
	logic                 e_fin;
	logic                 e_done;
	logic [2:0]           fin_phase;
	logic                 retx;
	logic                 has_result;
	logic                 need_div;
	logic [LW-1:0]        div_chunks;
	logic [PAYLOAD_W-1:0] div_last_bytes;
	logic [PAYLOAD_W-1:0] data_len;

	assign pay   = (payload_q == '0) ? PAYLOAD_W'(1) : payload_q;
	assign limit = (timeout_q == '0) ? TIMEOUT_W'(1) : timeout_q;

	// restoring division, one quotient bit a cycle
	assign trial     = {rem_q, quo_q[LW-1]};
	assign trial_ge  = (trial >= {1'b0, pay});
	assign trial_sub = trial - {1'b0, pay};

	assign div_chunks     = quo_q + LW'(rem_q != '0);
	assign div_last_bytes = (rem_q == '0) ? pay : rem_q;

	assign timer_inc = timer_q + TIMEOUT_W'(1);
	assign expired   = (timer_inc >= limit);

	always_comb begin
		n_phase   = phase_q;
		n_seq     = seq_q;
		n_chunks  = chunks_q;
		n_last    = last_q;
		n_offset  = offset_q;
		n_timer   = timer_q;
		e_data    = 1'b0;
		e_fin     = 1'b0;
		e_done    = 1'b0;
		fin_phase = PH_FIN;
		retx      = 1'b0;
		need_div  = 1'b0;
		unique case (kind_q)
			KIND_START: begin
				if (phase_q == PH_IDLE || phase_q == PH_DONE) begin
					if (!div_done_q) begin
						need_div = 1'b1;
					end else begin
						n_seq    = 1'b0;
						n_offset = '0;
						n_chunks = div_chunks;
						n_last   = div_last_bytes;
						if (div_chunks == '0) begin
							e_fin = 1'b1;
						end else begin
							e_data = 1'b1;
						end
					end
				end
			end
			KIND_TICK: begin
				if (phase_q == PH_DATA || phase_q == PH_FIN || phase_q == PH_LINGER) begin
					n_timer = expired ? '0 : timer_inc;
					if (expired) begin
						priority if (phase_q == PH_DATA) begin
							retx   = 1'b1;
							e_data = 1'b1;
						end else if (phase_q == PH_FIN) begin
							retx  = 1'b1;
							e_fin = 1'b1;
						end else begin
							e_done = 1'b1;
						end
					end
				end
			end
			KIND_FRAME: begin
				priority if (phase_q == PH_DATA) begin
					if (rxt_q == RX_ACK) begin
						if (rxs_q == seq_q) begin
							// stale ack: resend the same chunk
							retx   = 1'b1;
							e_data = 1'b1;
						end else begin
							n_seq    = ~seq_q;
							n_offset = offset_q + LW'(pay);
							n_chunks = (chunks_q != '0) ? chunks_q - LW'(1) : chunks_q;
							if (n_chunks == '0) begin
								e_fin = 1'b1;
							end else begin
								e_data = 1'b1;
							end
						end
					end
				end else if (phase_q == PH_FIN) begin
					e_fin     = 1'b1;
					fin_phase = PH_LINGER;
				end else if (phase_q == PH_LINGER) begin
					e_done = 1'b1;
				end
			end
			default: begin
			end
		endcase

		has_result = e_data | e_fin | e_done;
		if (has_result) begin
			n_timer = '0;
		end
		if (e_data) begin
			n_phase = PH_DATA;
		end else if (e_fin) begin
			n_phase = fin_phase;
		end else if (e_done) begin
			n_phase = PH_DONE;
		end
	end

	assign data_len = (n_chunks > LW'(1)) ? pay : n_last;

	assign sts.need_div   = need_div;
	assign sts.div_last   = (cnt_q == '0);
	assign sts.has_result = has_result;
	assign sts.out_free   = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			payload_q <= PAYLOAD_RST;
			timeout_q <= TIMEOUT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_PAYLOAD: payload_q <= cfg_data[PAYLOAD_W-1:0];
				CFG_TIMEOUT: timeout_q <= cfg_data[TIMEOUT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			seq_q    <= 1'b0;
			chunks_q <= '0;
			last_q   <= '0;
			offset_q <= '0;
			timer_q  <= '0;
		end else if (cmd.commit) begin
			phase_q  <= n_phase;
			seq_q    <= n_seq;
			chunks_q <= n_chunks;
			last_q   <= n_last;
			offset_q <= n_offset;
			timer_q  <= n_timer;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= '0;
			len_q  <= '0;
			rxt_q  <= '0;
			rxs_q  <= 1'b0;
		end else if (cmd.capture) begin
			kind_q <= in_kind;
			len_q  <= in_file_length[LW-1:0];
			rxt_q  <= in_rx_type;
			rxs_q  <= in_rx_seq;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			quo_q <= len_q;
			rem_q <= '0;
			cnt_q <= CW'(LW - 1);
		end else if (cmd.div_step) begin
			quo_q <= {quo_q[LW-2:0], trial_ge};
			rem_q <= trial_ge ? trial_sub[PAYLOAD_W-1:0] : trial[PAYLOAD_W-1:0];
			cnt_q <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_done_q <= 1'b0;
		end else if (cmd.capture) begin
			div_done_q <= 1'b0;
		end else if (cmd.div_step && sts.div_last) begin
			div_done_q <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.commit && has_result) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && has_result) begin
			out_action        <= e_data ? ACT_DATA : (e_fin ? ACT_FIN : ACT_DONE);
			out_seq_bit       <= e_data ? n_seq : 1'b0;
			out_chunks_left   <= e_data ? FILE_LEN_W'(n_chunks) : '0;
			out_frame_length  <= e_data ? data_len : '0;
			out_byte_offset   <= e_data ? FILE_LEN_W'(n_offset) : '0;
			out_is_retransmit <= retx;
		end
	end

`ifndef SYNTH
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && has_result |-> !out_valid || out_ready)
		else $error("result loaded over one not yet taken");

	a_data_has_chunk: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DATA |-> chunks_q != '0)
		else $error("data phase with no chunk left");

	a_timer_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_IDLE || phase_q == PH_DONE |-> timer_q == '0)
		else $error("timer running outside a waiting phase");

	a_div_result_used: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step && sts.div_last |=> need_div == 1'b0)
		else $error("division requested twice for one start item");
`endif

endmodule

@@ rtl/stop_and_wait_arq_sender.sv @@
// Sequence: a tick or frame item is captured into the item register, evaluated, and its result is
// loaded into the output register once the output slot is free; a start item that opens a transfer
// first runs the one-bit-per-cycle divider that splits the length into chunks.
// Flow: a new item is accepted only after the last one has been committed;
// a held result on the master side delays only the next item that has a result.
// Reset: arst_n clears phase to idle, seq, chunk, offset and timer to zero, payload to 232, timeout to 60.
module stop_and_wait_arq_sender
	import sawarq_pkg::*;
#(
	parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// input items
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // file_length[31:0], rx_type[33:32], rx_seq[34]
	input  logic [1:0]            s_tuser,   // kind
	// result items
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // seq_bit[0], chunks_left[32:1],
	                                         // frame_length[40:33], byte_offset[72:41],
	                                         // is_retransmit[73]
	output logic [1:0]            m_tuser,   // action
	// configuration writes
	input  logic                  cfg_we,
	input  logic                  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	ctl_cmd_t cmd;
	ctl_sts_t sts;

	logic                  seq_bit;
	logic [FILE_LEN_W-1:0] chunks_left;
	logic [PAYLOAD_W-1:0]  frame_length;
	logic [FILE_LEN_W-1:0] byte_offset;
	logic                  is_retransmit;

	// controller: accept, optional division, then commit once the output slot is free or there is no result
	sawarq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath: protocol state, timer, chunk divider and the output register
	sawarq_dpath #(
		.LENGTH_BITS (LENGTH_BITS)
	) u_dpath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sts               (sts),
		.in_kind           (s_tuser),
		.in_file_length    (s_tdata[31:0]),
		.in_rx_type        (s_tdata[33:32]),
		.in_rx_seq         (s_tdata[34]),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.out_ready         (m_tready),
		.out_valid         (m_tvalid),
		.out_action        (m_tuser),
		.out_seq_bit       (seq_bit),
		.out_chunks_left   (chunks_left),
		.out_frame_length  (frame_length),
		.out_byte_offset   (byte_offset),
		.out_is_retransmit (is_retransmit)
	);

	// pack result fields, lowest first, zero padding to whole bytes
	assign m_tdata = {6'd0, is_retransmit, byte_offset, frame_length, chunks_left, seq_bit};

endmodule
